// File: src/pdcc_pkg.sv
// Shared types and constants for the proximity door chime controller.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps
`default_nettype none
package pdcc_pkg;

  localparam int CNT_W  = 17;
  localparam int ECHO_W = 20;
  localparam int DIST_W = 15;
  localparam int THR_W  = 10;
  localparam int MS_W   = 16;
  localparam int IDX_W  = 3;
  localparam int POS_W  = 5;
  localparam int TONE_W = 2;

  // floor(x / 1000) for x < 2**25 as (x * DIV_RECIP) >> DIV_SHIFT
  localparam int DIV_SHIFT = 35;
  localparam int RECIP_W   = 26;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd34359739;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_HOLD      = 3'd1;
  localparam logic [IDX_W-1:0] REG_SAMPLE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CHIME     = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCROLL    = 3'd4;
  localparam logic [IDX_W-1:0] REG_FIRST     = 3'd5;
  localparam logic [IDX_W-1:0] REG_GAP       = 3'd6;
  localparam logic [IDX_W-1:0] REG_SECOND    = 3'd7;

  localparam logic [THR_W-1:0] RST_THRESHOLD = 10'd15;
  localparam logic [MS_W-1:0]  RST_HOLD      = 16'd2000;
  localparam logic [MS_W-1:0]  RST_SAMPLE    = 16'd100;
  localparam logic [MS_W-1:0]  RST_CHIME     = 16'd800;
  localparam logic [MS_W-1:0]  RST_SCROLL    = 16'd300;
  localparam logic [MS_W-1:0]  RST_FIRST     = 16'd100;
  localparam logic [MS_W-1:0]  RST_GAP       = 16'd50;
  localparam logic [MS_W-1:0]  RST_SECOND    = 16'd150;

  // buzzer codes
  localparam logic [TONE_W-1:0] TONE_OFF  = 2'd0;
  localparam logic [TONE_W-1:0] TONE_HIGH = 2'd1;
  localparam logic [TONE_W-1:0] TONE_LOW  = 2'd2;

  typedef struct packed {
    logic [THR_W-1:0] threshold_cm;
    logic [MS_W-1:0]  hold_ms;
    logic [MS_W-1:0]  sample_period_ms;
    logic [MS_W-1:0]  chime_period_ms;
    logic [MS_W-1:0]  scroll_period_ms;
    logic [MS_W-1:0]  first_tone_ms;
    logic [MS_W-1:0]  gap_ms;
    logic [MS_W-1:0]  second_tone_ms;
  } cfg_t;

  typedef struct packed {
    logic              relay_on;
    logic [TONE_W-1:0] tone_select;
    logic [DIST_W-1:0] distance_cm;
    logic              person_present;
    logic              scroll_update;
    logic [POS_W-1:0]  scroll_position;
  } res_t;

endpackage
`default_nettype wire

// File: src/pdcc_dist.sv
// Echo width to distance: floor(echo_us * 17 / 1000) in centimeters.
// Uses pdcc_pkg for widths and the reciprocal constant.
`timescale 1ns / 1ps
`default_nettype none
module pdcc_dist (
  input  wire logic [pdcc_pkg::ECHO_W-1:0] echo_us,
  output logic [pdcc_pkg::DIST_W-1:0]      distance_cm
);

  localparam int P_W    = pdcc_pkg::ECHO_W + 5;
  localparam int PROD_W = P_W + pdcc_pkg::RECIP_W;

  logic [P_W-1:0]    scaled;
  logic [PROD_W-1:0] prod;

  // times 17 as shift and add
  assign scaled = {1'b0, pdcc_pkg::ECHO_W'(echo_us), 4'b0000} + P_W'(echo_us);
  assign prod   = PROD_W'(scaled) * PROD_W'(pdcc_pkg::DIV_RECIP);
  assign distance_cm =
    prod[pdcc_pkg::DIV_SHIFT + pdcc_pkg::DIST_W - 1 : pdcc_pkg::DIV_SHIFT];

endmodule
`default_nettype wire

// File: src/pdcc_cfg.sv
// Configuration register file, written through a write enable that the top level drives from its valid/ready port.
// Uses pdcc_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none
module pdcc_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [pdcc_pkg::IDX_W-1:0] wr_index,
  input  wire logic [pdcc_pkg::MS_W-1:0]  wr_data,
  output pdcc_pkg::cfg_t                  cfg
);

  pdcc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_cm     <= pdcc_pkg::RST_THRESHOLD;
      cfg_r.hold_ms          <= pdcc_pkg::RST_HOLD;
      cfg_r.sample_period_ms <= pdcc_pkg::RST_SAMPLE;
      cfg_r.chime_period_ms  <= pdcc_pkg::RST_CHIME;
      cfg_r.scroll_period_ms <= pdcc_pkg::RST_SCROLL;
      cfg_r.first_tone_ms    <= pdcc_pkg::RST_FIRST;
      cfg_r.gap_ms           <= pdcc_pkg::RST_GAP;
      cfg_r.second_tone_ms   <= pdcc_pkg::RST_SECOND;
    end else if (wr_en) begin
      unique case (wr_index)
        pdcc_pkg::REG_THRESHOLD: cfg_r.threshold_cm <= wr_data[pdcc_pkg::THR_W-1:0];
        pdcc_pkg::REG_HOLD:      cfg_r.hold_ms          <= wr_data;
        pdcc_pkg::REG_SAMPLE:    cfg_r.sample_period_ms <= wr_data;
        pdcc_pkg::REG_CHIME:     cfg_r.chime_period_ms  <= wr_data;
        pdcc_pkg::REG_SCROLL:    cfg_r.scroll_period_ms <= wr_data;
        pdcc_pkg::REG_FIRST:     cfg_r.first_tone_ms    <= wr_data;
        pdcc_pkg::REG_GAP:       cfg_r.gap_ms           <= wr_data;
        pdcc_pkg::REG_SECOND:    cfg_r.second_tone_ms   <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: src/pdcc_core.sv
// Per-tick controller: elapsed timers, presence, relay hold, chime sequencer
// and marquee stepping. Uses pdcc_pkg for cfg_t, res_t and codes.
`timescale 1ns / 1ps
`default_nettype none
module pdcc_core #(
  parameter int SCROLL_POSITIONS = 22
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [pdcc_pkg::DIST_W-1:0] sample_cm,
  input  wire pdcc_pkg::cfg_t              cfg,
  output pdcc_pkg::res_t                   res
);

  localparam int CW = pdcc_pkg::CNT_W;
  localparam int PW = pdcc_pkg::POS_W;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_GAP  = 2'd2,
    PH_LOW  = 2'd3
  } phase_t;

  phase_t                    phase_r, phase_nxt, phase_mid;
  logic [pdcc_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic [CW-1:0] sample_r, sample_nxt;
  logic [CW-1:0] chime_r, chime_nxt;
  logic [CW-1:0] scroll_r, scroll_nxt;
  logic [CW-1:0] hold_r, hold_nxt;
  logic [CW-1:0] pel_r, pel_nxt, pel_mid;
  logic          door_r, door_nxt;
  logic [PW-1:0] mq_r, mq_nxt;
  logic [PW:0]   mq_inc;
  logic [CW-1:0] sample_b, chime_b, scroll_b, hold_b, pel_b;
  logic          present, relay;
  logic [pdcc_pkg::TONE_W-1:0] tone;
  logic          upd;
  logic [PW-1:0] pos;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    return (c == pdcc_pkg::CNT_SAT) ? c : c + CW'(1);
  endfunction

  always_comb begin
    sample_b = bump(sample_r);
    chime_b  = bump(chime_r);
    scroll_b = bump(scroll_r);
    hold_b   = bump(hold_r);
    pel_b    = bump(pel_r);

    sample_nxt = sample_b;
    dist_nxt   = dist_r;
    if (sample_b >= CW'(cfg.sample_period_ms)) begin
      sample_nxt = '0;
      dist_nxt   = sample_cm;
    end

    present    = (dist_nxt <= pdcc_pkg::DIST_W'(cfg.threshold_cm));
    chime_nxt  = chime_b;
    scroll_nxt = scroll_b;
    hold_nxt   = hold_b;
    door_nxt   = door_r;
    phase_mid  = phase_r;
    pel_mid    = pel_b;
    mq_nxt     = mq_r;
    mq_inc     = {1'b0, mq_r} + (PW+1)'(1);
    upd        = 1'b0;
    pos        = '0;

    if (present) begin
      door_nxt = 1'b1;
      hold_nxt = '0;
      relay    = 1'b1;
      // restart chime at the high tone
      if (chime_b >= CW'(cfg.chime_period_ms)) begin
        chime_nxt = '0;
        phase_mid = PH_HIGH;
        pel_mid   = '0;
      end
    end else begin
      relay     = door_r && (hold_b <= CW'(cfg.hold_ms));
      door_nxt  = relay;
      phase_mid = PH_IDLE;
      if (scroll_b >= CW'(cfg.scroll_period_ms)) begin
        scroll_nxt = '0;
        upd        = 1'b1;
        pos        = mq_r;
        mq_nxt     = (mq_inc >= (PW+1)'(SCROLL_POSITIONS)) ? '0 : mq_inc[PW-1:0];
      end
    end

    phase_nxt = phase_mid;
    pel_nxt   = pel_mid;
    tone      = pdcc_pkg::TONE_OFF;
    unique case (phase_mid)
      PH_HIGH: begin
        tone = pdcc_pkg::TONE_HIGH;
        if (pel_mid >= CW'(cfg.first_tone_ms)) begin
          pel_nxt   = '0;
          phase_nxt = PH_GAP;
          tone      = pdcc_pkg::TONE_OFF;
        end
      end
      PH_GAP: begin
        if (pel_mid >= CW'(cfg.gap_ms)) begin
          pel_nxt   = '0;
          phase_nxt = PH_LOW;
        end
      end
      PH_LOW: begin
        tone = pdcc_pkg::TONE_LOW;
        if (pel_mid >= CW'(cfg.second_tone_ms)) begin
          phase_nxt = PH_IDLE;
          tone      = pdcc_pkg::TONE_OFF;
        end
      end
      default: ;
    endcase

    res.relay_on        = relay;
    res.tone_select     = tone;
    res.distance_cm     = dist_nxt;
    res.person_present  = present;
    res.scroll_update   = upd;
    res.scroll_position = pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      dist_r   <= '0;
      sample_r <= pdcc_pkg::CNT_SAT;
      chime_r  <= pdcc_pkg::CNT_SAT;
      scroll_r <= pdcc_pkg::CNT_SAT;
      hold_r   <= pdcc_pkg::CNT_SAT;
      pel_r    <= '0;
      door_r   <= 1'b0;
      mq_r     <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      dist_r   <= dist_nxt;
      sample_r <= sample_nxt;
      chime_r  <= chime_nxt;
      scroll_r <= scroll_nxt;
      hold_r   <= hold_nxt;
      pel_r    <= pel_nxt;
      door_r   <= door_nxt;
      mq_r     <= mq_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/proximity_door_chime_controller.sv
// Proximity door chime controller, top level.
// A request in the input register moves to the result register once that is free.
// Throughput: one request per cycle while out_stall is low; the controller step
// is logic between the input and result registers, each holding one request.
// Reset (rst_n low, synchronous): registers return to defaults, timers expire.
// Depends on pdcc_pkg, pdcc_dist, pdcc_cfg and pdcc_core.
`timescale 1ns / 1ps
`default_nettype none
module proximity_door_chime_controller #(
  parameter int SCROLL_POSITIONS = 22
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [pdcc_pkg::ECHO_W-1:0] in_echo_us,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_relay_on,
  output logic [pdcc_pkg::TONE_W-1:0]      out_tone_select,
  output logic [pdcc_pkg::DIST_W-1:0]      out_distance_cm,
  output logic                             out_person_present,
  output logic                             out_scroll_update,
  output logic [pdcc_pkg::POS_W-1:0]       out_scroll_position,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pdcc_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [pdcc_pkg::MS_W-1:0]   cfg_data
);

  pdcc_pkg::cfg_t cfg;
  pdcc_pkg::res_t res, res_r;
  logic [pdcc_pkg::DIST_W-1:0] cm_in, cm_r;
  logic in_valid_r, out_valid_r;
  logic advance;

  assign cfg_ready = 1'b1;

  pdcc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pdcc_dist u_dist (
    .echo_us     (in_echo_us),
    .distance_cm (cm_in)
  );

  // move the held request into the result register when it is free
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  pdcc_core #(
    .SCROLL_POSITIONS (SCROLL_POSITIONS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .sample_cm (cm_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cm_r <= cm_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_relay_on        = res_r.relay_on;
  assign out_tone_select     = res_r.tone_select;
  assign out_distance_cm     = res_r.distance_cm;
  assign out_person_present  = res_r.person_present;
  assign out_scroll_update   = res_r.scroll_update;
  assign out_scroll_position = res_r.scroll_position;

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for proximity_door_chime_controller: echo requests in, one
// tick result out, checked against an in-bench model of the controller.
// Depends on pdcc_pkg and the controller sources under src.
`timescale 1ns / 1ps
module tb;

  localparam int MARQUEE_LEN = 22;

  typedef enum logic [1:0] {CH_IDLE, CH_HIGH, CH_GAP, CH_LOW} chime_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [pdcc_pkg::ECHO_W-1:0] in_echo_us = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [pdcc_pkg::IDX_W-1:0] cfg_index = '0;
  logic [pdcc_pkg::MS_W-1:0] cfg_data = '0;
  logic in_stall, out_valid, cfg_ready;
  logic out_relay_on, out_person_present, out_scroll_update;
  logic [pdcc_pkg::TONE_W-1:0] out_tone_select;
  logic [pdcc_pkg::DIST_W-1:0] out_distance_cm;
  logic [pdcc_pkg::POS_W-1:0] out_scroll_position;

  proximity_door_chime_controller #(.SCROLL_POSITIONS(MARQUEE_LEN)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_echo_us         (in_echo_us),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_relay_on       (out_relay_on),
    .out_tone_select    (out_tone_select),
    .out_distance_cm    (out_distance_cm),
    .out_person_present (out_person_present),
    .out_scroll_update  (out_scroll_update),
    .out_scroll_position(out_scroll_position),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // controller model state
  pdcc_pkg::cfg_t cfg_q;
  logic [pdcc_pkg::CNT_W-1:0] smp_age, chm_age, scr_age, hold_age, ph_age;
  logic [pdcc_pkg::DIST_W-1:0] dist_q;
  logic door_q;
  chime_phase_t phase_q;
  logic [pdcc_pkg::POS_W-1:0] marquee_q;

  pdcc_pkg::res_t tick_results_q[$];
  int mismatches = 0;
  int sender_idle_pct = 0;
  int rx_stall_pct = 0;

  function automatic void reset_model();
    cfg_q = '{pdcc_pkg::RST_THRESHOLD, pdcc_pkg::RST_HOLD, pdcc_pkg::RST_SAMPLE,
              pdcc_pkg::RST_CHIME, pdcc_pkg::RST_SCROLL, pdcc_pkg::RST_FIRST,
              pdcc_pkg::RST_GAP, pdcc_pkg::RST_SECOND};
    smp_age = pdcc_pkg::CNT_SAT;
    chm_age = pdcc_pkg::CNT_SAT;
    scr_age = pdcc_pkg::CNT_SAT;
    hold_age = pdcc_pkg::CNT_SAT;
    ph_age = '0;
    dist_q = '0;
    door_q = 1'b0;
    phase_q = CH_IDLE;
    marquee_q = '0;
  endfunction

  function automatic logic [pdcc_pkg::CNT_W-1:0] sat_inc(
      input logic [pdcc_pkg::CNT_W-1:0] c);
    return (c == pdcc_pkg::CNT_SAT) ? c : c + pdcc_pkg::CNT_W'(1);
  endfunction

  // advance the model by one millisecond tick
  function automatic pdcc_pkg::res_t door_tick(input logic [pdcc_pkg::ECHO_W-1:0] echo);
    pdcc_pkg::res_t r;
    int unsigned prod;
    logic present;
    r = '0;
    smp_age = sat_inc(smp_age);
    chm_age = sat_inc(chm_age);
    scr_age = sat_inc(scr_age);
    hold_age = sat_inc(hold_age);
    ph_age = sat_inc(ph_age);

    if (smp_age >= pdcc_pkg::CNT_W'(cfg_q.sample_period_ms)) begin
      smp_age = '0;
      prod = 32'(echo) * 32'd17;
      dist_q = pdcc_pkg::DIST_W'(prod / 32'd1000);
    end
    present = (dist_q <= pdcc_pkg::DIST_W'(cfg_q.threshold_cm));

    if (present) begin
      door_q = 1'b1;
      hold_age = '0;
      r.relay_on = 1'b1;
      if (chm_age >= pdcc_pkg::CNT_W'(cfg_q.chime_period_ms)) begin
        chm_age = '0;
        phase_q = CH_HIGH;
        ph_age = '0;
      end
    end else begin
      if (door_q && hold_age <= pdcc_pkg::CNT_W'(cfg_q.hold_ms)) begin
        r.relay_on = 1'b1;
      end else begin
        door_q = 1'b0;
      end
      phase_q = CH_IDLE;
      if (scr_age >= pdcc_pkg::CNT_W'(cfg_q.scroll_period_ms)) begin
        scr_age = '0;
        r.scroll_update = 1'b1;
        r.scroll_position = marquee_q;
        marquee_q = (marquee_q == pdcc_pkg::POS_W'(MARQUEE_LEN - 1)) ? '0
                    : marquee_q + pdcc_pkg::POS_W'(1);
      end
    end

    // the tick that leaves a tone phase is silent
    case (phase_q)
      CH_HIGH: begin
        r.tone_select = pdcc_pkg::TONE_HIGH;
        if (ph_age >= pdcc_pkg::CNT_W'(cfg_q.first_tone_ms)) begin
          ph_age = '0;
          phase_q = CH_GAP;
          r.tone_select = pdcc_pkg::TONE_OFF;
        end
      end
      CH_GAP: begin
        if (ph_age >= pdcc_pkg::CNT_W'(cfg_q.gap_ms)) begin
          ph_age = '0;
          phase_q = CH_LOW;
        end
      end
      CH_LOW: begin
        r.tone_select = pdcc_pkg::TONE_LOW;
        if (ph_age >= pdcc_pkg::CNT_W'(cfg_q.second_tone_ms)) begin
          phase_q = CH_IDLE;
          r.tone_select = pdcc_pkg::TONE_OFF;
        end
      end
      default: ;
    endcase

    r.distance_cm = dist_q;
    r.person_present = present;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    pdcc_pkg::res_t exp_r;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (tick_results_q.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got distance %0d",
                 $time, out_distance_cm);
        mismatches++;
      end else begin
        exp_r = tick_results_q.pop_front();
        check_field("relay_on", 32'(exp_r.relay_on), 32'(out_relay_on));
        check_field("tone_select", 32'(exp_r.tone_select), 32'(out_tone_select));
        check_field("distance_cm", 32'(exp_r.distance_cm), 32'(out_distance_cm));
        check_field("person_present", 32'(exp_r.person_present),
                    32'(out_person_present));
        check_field("scroll_update", 32'(exp_r.scroll_update), 32'(out_scroll_update));
        check_field("scroll_position", 32'(exp_r.scroll_position),
                    32'(out_scroll_position));
      end
    end
    out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  task automatic send_echo(input logic [pdcc_pkg::ECHO_W-1:0] echo);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_echo_us <= echo;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tick_results_q.push_back(door_tick(echo));
  endtask

  task automatic write_reg(input logic [pdcc_pkg::IDX_W-1:0] idx,
                           input logic [pdcc_pkg::MS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      pdcc_pkg::REG_THRESHOLD: cfg_q.threshold_cm = val[pdcc_pkg::THR_W-1:0];
      pdcc_pkg::REG_HOLD:      cfg_q.hold_ms = val;
      pdcc_pkg::REG_SAMPLE:    cfg_q.sample_period_ms = val;
      pdcc_pkg::REG_CHIME:     cfg_q.chime_period_ms = val;
      pdcc_pkg::REG_SCROLL:    cfg_q.scroll_period_ms = val;
      pdcc_pkg::REG_FIRST:     cfg_q.first_tone_ms = val;
      pdcc_pkg::REG_GAP:       cfg_q.gap_ms = val;
      pdcc_pkg::REG_SECOND:    cfg_q.second_tone_ms = val;
      default: ;
    endcase
  endtask

  // upper bits of the threshold write are junk and must be dropped
  task automatic program_regs(input pdcc_pkg::cfg_t c,
                              input logic [pdcc_pkg::MS_W-pdcc_pkg::THR_W-1:0] pad);
    write_reg(pdcc_pkg::REG_THRESHOLD, {pad, c.threshold_cm});
    write_reg(pdcc_pkg::REG_HOLD, c.hold_ms);
    write_reg(pdcc_pkg::REG_SAMPLE, c.sample_period_ms);
    write_reg(pdcc_pkg::REG_CHIME, c.chime_period_ms);
    write_reg(pdcc_pkg::REG_SCROLL, c.scroll_period_ms);
    write_reg(pdcc_pkg::REG_FIRST, c.first_tone_ms);
    write_reg(pdcc_pkg::REG_GAP, c.gap_ms);
    write_reg(pdcc_pkg::REG_SECOND, c.second_tone_ms);
    cfg_valid <= 1'b0;
  endtask

  // drop valid and wait until every tick result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [pdcc_pkg::MS_W-1:0] pick_ms(input int typ_hi, input int max_v);
    case ($urandom_range(0, 19))
      0: return '0;
      1: return pdcc_pkg::MS_W'(max_v);
      default: return pdcc_pkg::MS_W'($urandom_range(0, typ_hi));
    endcase
  endfunction

  function automatic pdcc_pkg::cfg_t random_settings();
    pdcc_pkg::cfg_t c;
    c.threshold_cm = pdcc_pkg::THR_W'(pick_ms(1023, 1023));
    c.hold_ms = pick_ms(40, 65535);
    c.sample_period_ms = pick_ms(6, 65535);
    c.chime_period_ms = pick_ms(30, 65535);
    c.scroll_period_ms = pick_ms(8, 65535);
    c.first_tone_ms = pick_ms(8, 65535);
    c.gap_ms = pick_ms(8, 65535);
    c.second_tone_ms = pick_ms(8, 65535);
    return c;
  endfunction

  // echo near a distance: the jitter always lands on that same distance
  function automatic logic [pdcc_pkg::ECHO_W-1:0] echo_near(input int cm);
    return pdcc_pkg::ECHO_W'((cm * 1000 + 16) / 17 + $urandom_range(0, 40));
  endfunction

  function automatic logic [pdcc_pkg::ECHO_W-1:0] make_echo(input int kind, input int thr);
    if (kind <= 4) return echo_near($urandom_range(0, thr));
    if (kind <= 7) return echo_near(thr + $urandom_range(1, 20));
    if (kind == 8) return '0;
    return pdcc_pkg::ECHO_W'($urandom);
  endfunction

  task automatic test_reset_defaults();
    // timeouts read as 0 cm, so the expired chime starts at once
    repeat (4) send_echo('0);
  endtask

  task automatic test_threshold_edges();
    logic [pdcc_pkg::ECHO_W-1:0] seq [8];
    settle();
    // threshold, hold, sample, chime, scroll, first, gap, second
    program_regs('{10'd15, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'd65535, 16'd65535, 16'd65535}, 6'h3F);
    seq = '{20'd941, 20'd942, 20'd0, 20'hFFFFF, 20'd1000000, 20'd882, 20'd942,
            20'd941};
    foreach (seq[i]) send_echo(seq[i]);
  endtask

  task automatic test_chime_phases();
    settle();
    program_regs('{10'd1023, 16'd65535, 16'd0, 16'd4, 16'd65535,
                   16'd0, 16'd0, 16'd0}, 6'h00);
    repeat (7) send_echo('0);
    repeat (3) send_echo(20'hFFFFF);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int sent;
    int seg_len;
    int kind;
    settle();
    program_regs(random_settings(), 6'($urandom));
    sender_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    sent = 0;
    // runs of presence and absence so timers and phases play out
    while (sent < n_items) begin
      seg_len = $urandom_range(1, 40);
      kind = $urandom_range(0, 9);
      repeat (seg_len) begin
        send_echo(make_echo(kind, int'(cfg_q.threshold_cm)));
        sent++;
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_threshold_edges();
    test_chime_phases();
    test_random_traffic(0, 0, 375);
    test_random_traffic(53, 0, 375);
    test_random_traffic(0, 53, 375);
    test_random_traffic(19, 19, 375);
    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
